// ----- sv/bsfp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and constants of the bms status frame parser
// no dependencies; imported by every module of the block

package bsfp_pkg;

  localparam int DEF_FRAME_BYTES = 64;
  localparam int DEF_MAX_CELLS   = 30;

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int TICK_W    = 16;
  localparam int VOLT_W    = 16;
  localparam int CUR_W     = 16;
  localparam int CHARGE_W  = 8;
  localparam int TEMP_W    = 17;
  localparam int CELLS_W   = 5;
  localparam int LOW_W     = 17;
  localparam int HIGH_W    = 16;
  localparam int OUT_DATA_W = VOLT_W + CUR_W + CHARGE_W + 2 * TEMP_W + CELLS_W + LOW_W + HIGH_W;

  localparam logic [BYTE_W-1:0] END_BYTE    = 8'h77;
  localparam logic [BYTE_W-1:0] HEAD_BYTE   = 8'hDD;
  localparam logic [BYTE_W-1:0] REPLY_BASIC = 8'h03;
  localparam logic [BYTE_W-1:0] REPLY_CELLS = 8'h04;
  localparam logic [TEMP_W-1:0] TEMP_OFFSET   = 17'd2731;
  localparam logic [LOW_W-1:0]  NO_CELL_LOW   = 17'd100000;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam int MIN_FRAME = 6;

  // byte positions inside a frame
  localparam int POS_HEAD       = 0;
  localparam int POS_CMD        = 1;
  localparam int POS_COUNT      = 3;
  localparam int POS_FIRST_CELL = 5;
  localparam int POS_VOLT_LO    = 5;
  localparam int POS_CUR_LO     = 7;
  localparam int POS_CHARGE     = 23;
  localparam int POS_T1_LO      = 28;
  localparam int POS_T2_LO      = 30;
  localparam int POS_BASIC_LAST = 30;

  typedef enum logic [OP_W-1:0] {
    OP_START_BASIC = 2'd0,
    OP_START_CELLS = 2'd1,
    OP_BYTE        = 2'd2,
    OP_TICK        = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_BASIC_OK = 3'd0,
    STS_CELLS_OK = 3'd1,
    STS_BAD_CMD  = 3'd2,
    STS_OVERFLOW = 3'd3,
    STS_TIMEOUT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BASIC = 2'd1,
    MODE_CELLS = 2'd2
  } mode_t;

  typedef struct packed {
    logic item_go;
    logic walk_start;
    logic walk_run;
    logic walk_finish;
  } dp_cmd_t;

  typedef struct packed {
    logic    emit_now;
    status_t emit_code;
    logic    frame_end;
    logic    walk_done;
    status_t walk_code;
  } dp_stat_t;

endpackage

// ----- sv/bms_status_frame_parser_unit.sv -----
`timescale 1ns / 1ps
// a start, ignored word or tick is simply taken; a timeout or overflow result is registered for next cycle
// a frame-ending byte starts a store walk, one read per cycle, to position 30 for a basic read,
// to max(30, 2*cells+3) for a cell-answered cell read, result shown the cycle after the walk
// throughput: one word per cycle outside walks; input stalls during a walk or a waiting result
// reset: synchronous active-low rst_n clears control, store valid bits and held values
module bms_status_frame_parser_unit #(
  parameter int FRAME_BYTES = bsfp_pkg::DEF_FRAME_BYTES,
  parameter int MAX_CELLS   = bsfp_pkg::DEF_MAX_CELLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bsfp_pkg::BYTE_W-1:0]     in_tdata,   // data_byte[7:0]
  input  logic [bsfp_pkg::OP_W-1:0]       in_tuser,   // operation[1:0]
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // pack_voltage_cv[15:0], pack_current_ca[31:16], charge_level[39:32],
  // temp_first_dc[56:40], temp_second_dc[73:57], cells_in_pack[78:74],
  // cell_min_mv[95:79], cell_max_mv[111:96]
  output logic [bsfp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [bsfp_pkg::STATUS_W-1:0]   out_tuser,  // status[2:0]
  // timeout register write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsfp_pkg::TICK_W-1:0]     cfg_data    // timeout_ticks[15:0]
);
  import bsfp_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [VOLT_W-1:0]   pack_voltage_cv;
  logic [CUR_W-1:0]    pack_current_ca;
  logic [CHARGE_W-1:0] charge_level;
  logic [TEMP_W-1:0]   temp_first_dc;
  logic [TEMP_W-1:0]   temp_second_dc;
  logic [CELLS_W-1:0]  cells_in_pack;
  logic [LOW_W-1:0]    cell_min_mv;
  logic [HIGH_W-1:0]   cell_max_mv;

  // register write always taken; the user must write it only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  bsfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_status(out_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  bsfp_datapath #(
    .FRAME_BYTES(FRAME_BYTES),
    .MAX_CELLS  (MAX_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .op_in          (in_tuser),
    .byte_in        (in_tdata),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_wdata      (cfg_data),
    .pack_voltage_cv(pack_voltage_cv),
    .pack_current_ca(pack_current_ca),
    .charge_level   (charge_level),
    .temp_first_dc  (temp_first_dc),
    .temp_second_dc (temp_second_dc),
    .cells_in_pack  (cells_in_pack),
    .cell_min_mv    (cell_min_mv),
    .cell_max_mv    (cell_max_mv)
  );

  // held values only change during a walk, which never overlaps a waiting result
  assign out_tdata = {cell_max_mv, cell_min_mv, cells_in_pack, temp_second_dc,
                      temp_first_dc, charge_level, pack_current_ca, pack_voltage_cv};

endmodule

// ----- sv/bsfp_store.sv -----
`timescale 1ns / 1ps
// frame byte store: one write port, one registered read port, valid bit per entry
// depends on bsfp_pkg

module bsfp_store #(
  parameter int FRAME_BYTES = bsfp_pkg::DEF_FRAME_BYTES,
  parameter int PW          = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [$clog2(FRAME_BYTES)-1:0] wr_addr,
  input  logic [bsfp_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [PW-1:0]               rd_pos,
  output logic [bsfp_pkg::BYTE_W-1:0] rd_data
);
  import bsfp_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);

  logic [BYTE_W-1:0] mem_r [FRAME_BYTES];
  logic [FRAME_BYTES-1:0] vld_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic [31:0] pos_ext;
  logic [AW-1:0] rd_idx;
  logic in_range;

  assign pos_ext  = 32'(rd_pos);
  assign rd_idx   = pos_ext[AW-1:0];
  assign in_range = pos_ext < FRAME_BYTES;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= (in_range && vld_r[rd_idx]) ? mem_r[rd_idx] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/bsfp_datapath.sv -----
`timescale 1ns / 1ps
// datapath: read state, counters, timeout register, frame walk and held values
// depends on bsfp_pkg and bsfp_store

module bsfp_datapath #(
  parameter int FRAME_BYTES = bsfp_pkg::DEF_FRAME_BYTES,
  parameter int MAX_CELLS   = bsfp_pkg::DEF_MAX_CELLS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bsfp_pkg::dp_cmd_t              cmd,
  output bsfp_pkg::dp_stat_t             stat,
  input  logic [bsfp_pkg::OP_W-1:0]      op_in,
  input  logic [bsfp_pkg::BYTE_W-1:0]    byte_in,
  input  logic                           cfg_we,
  input  logic [bsfp_pkg::TICK_W-1:0]    cfg_wdata,
  output logic [bsfp_pkg::VOLT_W-1:0]    pack_voltage_cv,
  output logic [bsfp_pkg::CUR_W-1:0]     pack_current_ca,
  output logic [bsfp_pkg::CHARGE_W-1:0]  charge_level,
  output logic [bsfp_pkg::TEMP_W-1:0]    temp_first_dc,
  output logic [bsfp_pkg::TEMP_W-1:0]    temp_second_dc,
  output logic [bsfp_pkg::CELLS_W-1:0]   cells_in_pack,
  output logic [bsfp_pkg::LOW_W-1:0]     cell_min_mv,
  output logic [bsfp_pkg::HIGH_W-1:0]    cell_max_mv
);
  import bsfp_pkg::*;

  localparam int AW       = $clog2(FRAME_BYTES);
  localparam int CNTW     = $clog2(FRAME_BYTES + 1);
  localparam int NW       = $clog2(MAX_CELLS + 1);
  localparam int LAST_POS = (2 * MAX_CELLS + 3 > POS_BASIC_LAST) ?
                            2 * MAX_CELLS + 3 : POS_BASIC_LAST;
  localparam int PW       = $clog2(LAST_POS + 1);

  op_t op;
  assign op = op_t'(op_in);

  // read state
  mode_t mode_r, mode_nxt;
  logic [CNTW-1:0] count_r, count_nxt, cnt_inc;
  logic [TICK_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [TICK_W-1:0] timeout_r;
  logic wr_en;

  // status toward the controller
  logic    emit_now_c;
  status_t emit_code_c;
  logic    frame_end_c;
  logic    walk_done_c;
  status_t walk_code_c;

  // walk
  logic [PW-1:0] rd_pos_r, tag_r, cell_last, walk_last;
  logic rd_vld_r, proc;
  logic [BYTE_W-1:0] rd_data, prev_r, cmd_r;
  logic head_ok_r;
  logic [NW-1:0] n_r, n_clamped;
  logic [BYTE_W-2:0] n_raw;
  logic [2*BYTE_W-1:0] pair;
  logic cells_go, cell_hit;
  logic [LOW_W-1:0] lo_w_r, lo_new;
  logic [HIGH_W-1:0] hi_w_r, hi_new;

  // held values
  logic [VOLT_W-1:0] volt_r;
  logic signed [CUR_W-1:0] cur_r;
  logic [CHARGE_W-1:0] charge_r;
  logic signed [TEMP_W-1:0] t1_r, t2_r;
  logic [NW-1:0] cell_count_r;
  logic [LOW_W-1:0] cell_low_r;
  logic [HIGH_W-1:0] cell_high_r;

  assign cnt_inc  = count_r + CNTW'(1);
  assign tick_inc = tick_r + TICK_W'(1);

  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    tick_nxt    = tick_r;
    wr_en       = 1'b0;
    emit_now_c  = 1'b0;
    emit_code_c = STS_TIMEOUT;
    frame_end_c = 1'b0;
    if (cmd.item_go) begin
      unique case (op)
        OP_START_BASIC, OP_START_CELLS: begin
          mode_nxt  = (op == OP_START_BASIC) ? MODE_BASIC : MODE_CELLS;
          count_nxt = '0;
          tick_nxt  = '0;
        end
        OP_TICK: begin
          if (mode_r != MODE_IDLE) begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              emit_now_c  = 1'b1;
              emit_code_c = STS_TIMEOUT;
              mode_nxt    = MODE_IDLE;
            end
          end
        end
        OP_BYTE: begin
          if (mode_r != MODE_IDLE) begin
            wr_en     = 32'(count_r) < FRAME_BYTES;
            count_nxt = cnt_inc;
            if (byte_in == END_BYTE && 32'(cnt_inc) > MIN_FRAME) begin
              frame_end_c = 1'b1;
            end else if (32'(cnt_inc) >= FRAME_BYTES) begin
              emit_now_c  = 1'b1;
              emit_code_c = STS_OVERFLOW;
              mode_nxt    = MODE_IDLE;
            end
          end
        end
      endcase
    end
    if (cmd.walk_finish) begin
      mode_nxt = MODE_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      count_r   <= '0;
      tick_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      tick_r  <= tick_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  bsfp_store #(
    .FRAME_BYTES(FRAME_BYTES),
    .PW         (PW)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(byte_in),
    .rd_en  (cmd.walk_run),
    .rd_pos (rd_pos_r),
    .rd_data(rd_data)
  );

  // read one position per cycle; data and its tag are registered and arrive in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.walk_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      rd_pos_r <= '0;
    end else if (cmd.walk_run) begin
      rd_pos_r <= rd_pos_r + PW'(1);
    end
    if (cmd.walk_run) begin
      tag_r <= rd_pos_r;
    end
  end

  assign proc      = rd_vld_r && cmd.walk_run;
  assign pair      = {prev_r, rd_data};
  assign n_raw     = rd_data[BYTE_W-1:1];
  assign n_clamped = (32'(n_raw) > MAX_CELLS) ? NW'(MAX_CELLS) : NW'(n_raw);
  assign cells_go  = (mode_r == MODE_CELLS) && (cmd_r == REPLY_CELLS);
  assign cell_last = PW'({n_r, 1'b0}) + PW'(3);
  assign walk_last = (cells_go && cell_last > PW'(POS_BASIC_LAST)) ?
                     cell_last : PW'(POS_BASIC_LAST);
  assign cell_hit  = proc && tag_r[0] && tag_r >= PW'(POS_FIRST_CELL) && tag_r <= cell_last;
  assign lo_new    = (cell_hit && LOW_W'(pair) < lo_w_r) ? LOW_W'(pair) : lo_w_r;
  assign hi_new    = (cell_hit && pair > hi_w_r) ? pair : hi_w_r;

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      lo_w_r <= NO_CELL_LOW;
      hi_w_r <= '0;
    end else if (proc) begin
      lo_w_r <= lo_new;
      hi_w_r <= hi_new;
    end
    if (proc) begin
      prev_r <= rd_data;
      if (tag_r == PW'(POS_HEAD))  head_ok_r <= (rd_data == HEAD_BYTE);
      if (tag_r == PW'(POS_CMD))   cmd_r <= rd_data;
      if (tag_r == PW'(POS_COUNT)) n_r <= n_clamped;
    end
  end

  assign walk_done_c = proc && (tag_r == walk_last);

  always_comb begin
    priority if (mode_r == MODE_CELLS) begin
      walk_code_c = (cmd_r == REPLY_CELLS) ? STS_CELLS_OK : STS_BAD_CMD;
    end else begin
      walk_code_c = (cmd_r == REPLY_BASIC) ? STS_BASIC_OK : STS_BAD_CMD;
    end
  end

  assign stat = {emit_now_c, emit_code_c, frame_end_c, walk_done_c, walk_code_c};

  // held values: basic fields only when the header matches
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      volt_r      <= '0;
      cur_r       <= '0;
      charge_r    <= '0;
      t1_r        <= '0;
      t2_r        <= '0;
      cell_count_r <= '0;
      cell_low_r  <= NO_CELL_LOW;
      cell_high_r <= '0;
    end else begin
      if (proc && head_ok_r) begin
        if (tag_r == PW'(POS_VOLT_LO)) volt_r   <= pair;
        if (tag_r == PW'(POS_CUR_LO))  cur_r    <= pair;
        if (tag_r == PW'(POS_CHARGE))  charge_r <= rd_data;
        if (tag_r == PW'(POS_T1_LO))   t1_r     <= {1'b0, pair} - TEMP_OFFSET;
        if (tag_r == PW'(POS_T2_LO))   t2_r     <= {1'b0, pair} - TEMP_OFFSET;
      end
      if (cmd.walk_finish && cells_go) begin
        cell_count_r <= n_r;
        cell_low_r   <= lo_new;
        cell_high_r  <= hi_new;
      end
    end
  end

  assign pack_voltage_cv = volt_r;
  assign pack_current_ca = cur_r;
  assign charge_level    = charge_r;
  assign temp_first_dc   = t1_r;
  assign temp_second_dc  = t2_r;
  assign cells_in_pack   = CELLS_W'(cell_count_r);
  assign cell_min_mv     = cell_low_r;
  assign cell_max_mv     = cell_high_r;

endmodule

// ----- sv/bsfp_ctrl.sv -----
`timescale 1ns / 1ps
// controller: input and result handshakes, frame walk sequencing, result status register
// depends on bsfp_pkg

module bsfp_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bsfp_pkg::STATUS_W-1:0] out_status,
  output bsfp_pkg::dp_cmd_t             cmd,
  input  bsfp_pkg::dp_stat_t            stat
);
  import bsfp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  status_t status_r;
  logic accept, load;
  status_t load_code;

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // item_go, walk_start, walk_run, walk_finish
  assign cmd = {accept, accept && stat.frame_end, state_r == ST_WALK,
                (state_r == ST_WALK) && stat.walk_done};

  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    load_code = stat.emit_code;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && stat.frame_end) begin
          state_nxt = ST_WALK;
        end
        load = accept && stat.emit_now;
      end
      ST_WALK: begin
        if (stat.walk_done) begin
          state_nxt = ST_IDLE;
          load      = 1'b1;
          load_code = stat.walk_code;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= load_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_status = status_r;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (load && out_valid_r) |-> out_tready)
    else $error("result word loaded over an untaken result");

  a_walk_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_WALK) |-> $past(accept && stat.frame_end))
    else $error("frame walk started without an ending byte");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stat.emit_now) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("timeout or overflow result not presented");
`endif

endmodule

// ----- bench/bms_status_frame_parser_unit_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for the bms status frame parser: directed reads, then random frames
// depends on bsfp_pkg and bms_status_frame_parser_unit; nothing else

module bms_status_frame_parser_unit_test;
  import bsfp_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;  // watchdog, far beyond the slowest correct run
  localparam int SETTLE       = 100;        // covers the longest store walk, up to position 2*30+3, plus the result
  localparam int LONG_HOLD    = 400;        // receiver back-pressure stretch
  localparam int PHASE_WORDS  = 100;

  typedef logic [7:0] byte_q_t[$];

  // one report the parser should hand out
  typedef struct {
    status_t            status;
    logic [15:0]        voltage;
    logic signed [15:0] current;
    logic [7:0]         charge;
    logic signed [16:0] temp_first;
    logic signed [16:0] temp_second;
    logic [4:0]         cells;
    logic [16:0]        cell_low;
    logic [15:0]        cell_high;
  } pack_report_t;

  // predicts the reports from accepted words and checks them in order
  class frame_checker;
    logic [7:0]         store [DEF_FRAME_BYTES];
    int unsigned        stored;
    mode_t              mode;
    logic [15:0]        ticks;
    logic [15:0]        timeout_ticks;
    logic [15:0]        voltage;
    logic signed [15:0] current;
    logic [7:0]         charge;
    logic signed [16:0] temp_first;
    logic signed [16:0] temp_second;
    logic [4:0]         cells;
    logic [16:0]        cell_low;
    logic [15:0]        cell_high;
    pack_report_t       reports_due[$];
    int                 errors;
    int                 reports_seen;
    int                 status_seen[5];

    function new();
      foreach (store[i]) store[i] = 8'h00;
      stored = 0;
      mode = MODE_IDLE;
      ticks = '0;
      timeout_ticks = TIMEOUT_RESET;
      voltage = '0;
      current = '0;
      charge = '0;
      temp_first = '0;
      temp_second = '0;
      cells = '0;
      cell_low = NO_CELL_LOW;
      cell_high = '0;
      errors = 0;
      reports_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // positions past the store read as zero
    function logic [7:0] byte_at(int pos);
      return (pos < DEF_FRAME_BYTES) ? store[pos] : 8'h00;
    endfunction

    function logic [15:0] pair_at(int pos);
      return {byte_at(pos), byte_at(pos + 1)};
    endfunction

    function void finish_read(status_t s);
      pack_report_t r;
      r.status = s;
      r.voltage = voltage;
      r.current = current;
      r.charge = charge;
      r.temp_first = temp_first;
      r.temp_second = temp_second;
      r.cells = cells;
      r.cell_low = cell_low;
      r.cell_high = cell_high;
      reports_due.push_back(r);
      mode = MODE_IDLE;
    endfunction

    function void note_word(op_t op, logic [7:0] b);
      int          n;
      logic [15:0] mv;
      logic [16:0] lo;
      logic [15:0] hi;
      if (op == OP_START_BASIC || op == OP_START_CELLS) begin
        // restart keeps the stored bytes
        mode = (op == OP_START_BASIC) ? MODE_BASIC : MODE_CELLS;
        stored = 0;
        ticks = '0;
        return;
      end
      if (mode == MODE_IDLE) return;
      if (op == OP_TICK) begin
        ticks = ticks + 16'd1;
        if (ticks >= timeout_ticks) finish_read(STS_TIMEOUT);
        return;
      end
      if (stored < DEF_FRAME_BYTES) store[stored] = b;
      stored++;
      if (b == END_BYTE && stored > MIN_FRAME) begin
        if (byte_at(0) == HEAD_BYTE) begin
          voltage = pair_at(4);
          current = pair_at(6);
          charge = byte_at(23);
          temp_first = 17'(int'(pair_at(27)) - int'(TEMP_OFFSET));
          temp_second = 17'(int'(pair_at(29)) - int'(TEMP_OFFSET));
        end
        if (mode == MODE_BASIC) begin
          finish_read((byte_at(1) == REPLY_BASIC) ? STS_BASIC_OK : STS_BAD_CMD);
        end else if (byte_at(1) != REPLY_CELLS) begin
          finish_read(STS_BAD_CMD);
        end else begin
          n = int'(byte_at(3) >> 1);
          if (n > DEF_MAX_CELLS) n = DEF_MAX_CELLS;
          lo = NO_CELL_LOW;
          hi = '0;
          for (int k = 0; k < n; k++) begin
            mv = pair_at(4 + 2 * k);
            if ({1'b0, mv} < lo) lo = {1'b0, mv};
            if (mv > hi) hi = mv;
          end
          cells = 5'(n);
          cell_low = lo;
          cell_high = hi;
          finish_read(STS_CELLS_OK);
        end
      end else if (stored >= DEF_FRAME_BYTES) begin
        finish_read(STS_OVERFLOW);
      end
    endfunction

    function void compare(string name, logic signed [63:0] e, logic signed [63:0] a);
      if (a !== e) begin
        $error("%s expected %0d actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_report(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] d);
      pack_report_t r;
      if (reports_due.size() == 0) begin
        $error("report with status %0d arrived with none due", status);
        errors++;
        return;
      end
      r = reports_due.pop_front();
      reports_seen++;
      if (status < 5) status_seen[status]++;
      compare("status", r.status, status);
      compare("pack_voltage_cv", r.voltage, d[15:0]);
      compare("pack_current_ca", r.current, $signed(d[31:16]));
      compare("charge_level", r.charge, d[39:32]);
      compare("temp_first_dc", r.temp_first, $signed(d[56:40]));
      compare("temp_second_dc", r.temp_second, $signed(d[73:57]));
      compare("cells_in_pack", r.cells, d[78:74]);
      compare("cell_min_mv", r.cell_low, d[95:79]);
      compare("cell_max_mv", r.cell_high, d[111:96]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [TICK_W-1:0]     cfg_data;

  frame_checker board;
  int burst_left   = 0;   // words left in the current sender burst
  int words_sent   = 0;
  int tick_pct     = 0;   // chance of a tick slipped in before each frame byte
  bit hold_request = 0;   // asks the receiver for one long stall
  int cycle_count  = 0;

  bms_status_frame_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // data_byte[7:0]
    .in_tuser   (in_tuser),    // operation[1:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // voltage, current, charge, temps, cells, min, max from bit 0 up
    .out_tuser  (out_tuser),   // status[2:0]
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)     // timeout_ticks[15:0]
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver: checks every accepted report, then picks next cycle's ready
  initial begin
    int hold_left;
    int rx_rate;
    int rx_cycle;
    hold_left = 0;
    rx_rate = 100;
    rx_cycle = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid === 1'b1 && out_tready) board.check_report(out_tuser, out_tdata);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 0;
      end
      // the ready rate is redrawn periodically, full rate included
      if (rx_cycle % 300 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            rx_rate = 100;
          end
          1: begin
            rx_rate = 70;
          end
          default: begin
            rx_rate = 35;
          end
        endcase
      end
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(1, 100) <= rx_rate);
      end
    end
  end

  function automatic logic [7:0] no_end(logic [7:0] b);
    return (b == END_BYTE) ? b + 8'd1 : b;
  endfunction

  // basic reply: head, cmd, status, length, fields at fixed positions, random filler, end byte
  function automatic void build_basic(ref byte_q_t q, input logic [7:0] head, cmd,
                                      logic [15:0] volt, cur, logic [7:0] charge,
                                      logic [15:0] t1, t2, int extra);
    q.delete();
    q.push_back(head);
    q.push_back(cmd);
    q.push_back(8'h00);
    q.push_back(no_end(8'(27 + extra)));
    q.push_back(no_end(volt[15:8]));
    q.push_back(no_end(volt[7:0]));
    q.push_back(no_end(cur[15:8]));
    q.push_back(no_end(cur[7:0]));
    while (q.size() < 23) q.push_back(no_end(8'($urandom)));
    q.push_back(no_end(charge));
    while (q.size() < 27) q.push_back(no_end(8'($urandom)));
    q.push_back(no_end(t1[15:8]));
    q.push_back(no_end(t1[7:0]));
    q.push_back(no_end(t2[15:8]));
    q.push_back(no_end(t2[7:0]));
    repeat (extra + 2) q.push_back(no_end(8'($urandom)));
    q.push_back(END_BYTE);
  endfunction

  // cell reply: first cell at lo_mv, second at hi_mv, the rest in between
  function automatic void build_cells(ref byte_q_t q, input logic [7:0] head, cmd, count_byte,
                                      int n, logic [15:0] lo_mv, hi_mv, bit tail);
    logic [15:0] mv;
    q.delete();
    q.push_back(head);
    q.push_back(cmd);
    q.push_back(8'h00);
    q.push_back(count_byte);
    for (int k = 0; k < n; k++) begin
      mv = (k == 0) ? lo_mv : (k == 1) ? hi_mv : 16'($urandom_range(hi_mv, lo_mv));
      q.push_back(no_end(mv[15:8]));
      q.push_back(no_end(mv[7:0]));
    end
    if (tail) begin
      q.push_back(no_end(8'($urandom)));
      q.push_back(no_end(8'($urandom)));
      q.push_back(END_BYTE);
    end
  endfunction

  // offers one word, idling between bursts, and returns once it is taken
  task automatic send_word(op_t op, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    board.note_word(op, b);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_frame(op_t start, byte_q_t q, int pct);
    send_word(start, 8'($urandom));
    foreach (q[i]) begin
      if ($urandom_range(0, 99) < pct) send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, q[i]);
    end
  endtask

  // register writes only once every report is out and the store walk has surely ended
  task automatic write_timeout(logic [15:0] v);
    in_tvalid <= 1'b0;
    while (board.reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    board.timeout_ticks = v;
  endtask

  // well-formed frame with random content, sometimes broken: header, command, mode, count, cut
  task automatic random_frame();
    byte_q_t     q;
    op_t         start;
    logic [7:0]  head;
    logic [7:0]  cmd;
    logic [15:0] t1;
    logic [15:0] t2;
    int          n;
    head = ($urandom_range(0, 9) == 0) ? 8'($urandom) : HEAD_BYTE;
    if ($urandom_range(0, 1) == 0) begin
      cmd = ($urandom_range(0, 9) == 0) ? 8'($urandom) : REPLY_BASIC;
      t1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2331, 3331));
      t2 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(2331, 3331));
      build_basic(q, head, cmd, 16'($urandom), 16'($urandom), 8'($urandom), t1, t2,
                  $urandom_range(0, 8));
      start = ($urandom_range(0, 9) == 0) ? OP_START_CELLS : OP_START_BASIC;
    end else begin
      // mostly small packs; a wide one can run past the store and overflow
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, DEF_MAX_CELLS) : $urandom_range(0, 6);
      cmd = ($urandom_range(0, 9) == 0) ? REPLY_BASIC : REPLY_CELLS;
      if ($urandom_range(0, 7) == 0)
        build_cells(q, head, cmd, 8'($urandom), n, 16'h0000, 16'hFFFF, 1'b1);
      else
        build_cells(q, head, cmd, 8'(2 * n + $urandom_range(0, 1)), n,
                    16'($urandom_range(2500, 3300)), 16'($urandom_range(3300, 4300)), 1'b1);
      start = ($urandom_range(0, 9) == 0) ? OP_START_BASIC : OP_START_CELLS;
    end
    // a stray end byte cuts the frame short
    if ($urandom_range(0, 9) == 0) q[$urandom_range(6, q.size() - 2)] = END_BYTE;
    send_frame(start, q, tick_pct);
  endtask

  initial begin
    byte_q_t     q;
    int          pick;
    logic [15:0] limits [5];
    int          phase_start;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_START_BASIC;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // a zero limit fails on the very first tick
    write_timeout(16'd0);
    // bytes and ticks with no read running are dropped
    send_word(OP_TICK, 8'hFF);
    send_word(OP_BYTE, HEAD_BYTE);
    send_word(OP_START_BASIC, 8'h00);
    send_word(OP_TICK, 8'h00);

    // smallest real limit: one tick ends a cell read
    write_timeout(16'd1);
    send_word(OP_START_CELLS, 8'hFF);
    send_word(OP_BYTE, HEAD_BYTE);
    send_word(OP_TICK, 8'h55);

    write_timeout(16'hFFFF);
    // basic read with extreme field values
    build_basic(q, HEAD_BYTE, REPLY_BASIC, 16'hFFFF, 16'h8000, 8'hFF, 16'h0000, 16'hFFFF, 0);
    send_frame(OP_START_BASIC, q, 0);
    // basic read answered with the cell command: values latch, status says wrong command
    build_basic(q, HEAD_BYTE, REPLY_CELLS, 16'h0000, 16'h7FFF, 8'h00, 16'd2731, 16'd2730, 3);
    send_frame(OP_START_BASIC, q, 0);
    // cell read reporting no cells
    build_cells(q, HEAD_BYTE, REPLY_CELLS, 8'h00, 0, 16'd0, 16'd0, 1'b1);
    send_frame(OP_START_CELLS, q, 0);
    // count byte far above the clamp, end byte in the last slot of the store
    build_cells(q, HEAD_BYTE, REPLY_CELLS, 8'hFF, DEF_MAX_CELLS, 16'd2000, 16'd4500, 1'b0);
    q[DEF_FRAME_BYTES - 1] = END_BYTE;
    send_frame(OP_START_CELLS, q, 0);
    // bad header: basic values untouched, cells still extracted, extreme cell values
    build_cells(q, 8'h5A, REPLY_CELLS, 8'h06, 3, 16'h0000, 16'hFFFF, 1'b1);
    send_frame(OP_START_CELLS, q, 0);
    // cell read answered with the basic command
    build_cells(q, HEAD_BYTE, REPLY_BASIC, 8'h08, 4, 16'd3000, 16'd3400, 1'b1);
    send_frame(OP_START_CELLS, q, 0);
    // early end byte is just data; the short frame parses stale store contents
    q = '{HEAD_BYTE, REPLY_BASIC, END_BYTE, 8'h00, 8'h00, 8'h00, END_BYTE};
    send_frame(OP_START_BASIC, q, 0);
    // a full store with no end byte
    q.delete();
    for (int i = 0; i < DEF_FRAME_BYTES; i++) q.push_back(no_end(8'(i * 37 + 11)));
    send_frame(OP_START_CELLS, q, 0);
    // restart in the middle of a read, odd count byte
    q = '{HEAD_BYTE, REPLY_BASIC, 8'h01};
    send_frame(OP_START_BASIC, q, 0);
    build_cells(q, HEAD_BYTE, REPLY_CELLS, 8'h05, 2, 16'd3100, 16'd3600, 1'b1);
    send_frame(OP_START_CELLS, q, 0);
    // basic read with a foreign header still reports ok
    build_basic(q, 8'hA5, REPLY_BASIC, 16'h1234, 16'hFEDC, 8'h32, 16'h0B00, 16'h0C00, 1);
    send_frame(OP_START_BASIC, q, 0);

    // ---- random part ----
    limits[0] = 16'd2;
    limits[1] = 16'd40;
    limits[2] = TIMEOUT_RESET;
    limits[3] = 16'hFFFF;
    limits[4] = 16'($urandom_range(1, 65535));
    tick_pct = 4;
    for (int p = 0; p < 5; p++) begin
      write_timeout(limits[p]);
      // long receiver stall while words keep coming: the parser must back up its input
      if (p == 1 || p == 3) hold_request = 1;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS || (p == 4 && board.reports_seen < 40)) begin
        pick = $urandom_range(0, 99);
        if (pick < 76) begin
          random_frame();
        end else if (pick < 86) begin
          q.delete();
          repeat (DEF_FRAME_BYTES) q.push_back(no_end(8'($urandom)));
          send_frame(op_t'($urandom_range(0, 1)), q, tick_pct);
        end else if (pick < 94 && board.timeout_ticks <= 64) begin
          // run the tick count right up to the limit
          send_word(op_t'($urandom_range(0, 1)), 8'($urandom));
          repeat (board.timeout_ticks) send_word(OP_TICK, 8'($urandom));
        end else begin
          repeat (16) send_word(op_t'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    end

    // drain
    in_tvalid <= 1'b0;
    while (board.reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d words over %0d cycles, %0d reports checked", words_sent, cycle_count,
             board.reports_seen);
    $display("reports: basic %0d, cells %0d, wrong command %0d, overflow %0d, timeout %0d",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4]);
    if (board.errors == 0 && board.reports_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bsfp_pkg.sv
sv/bsfp_store.sv
sv/bsfp_datapath.sv
sv/bsfp_ctrl.sv
sv/bms_status_frame_parser_unit.sv
bench/bms_status_frame_parser_unit_test.sv
